// ===== rtl/field_current_sense_and_param_lookup_top_assert.svh =====
// Assertion macros shared by the RTL of the field-current sense block.
// Each expects aclk and aresetn in the scope where it is used.
`ifndef FIELD_CURRENT_SENSE_AND_PARAM_LOOKUP_TOP_ASSERT_SVH
`define FIELD_CURRENT_SENSE_AND_PARAM_LOOKUP_TOP_ASSERT_SVH

// Same-cycle implication.
`define FCSPL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define FCSPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/fcspl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fcspl_pkg;

    localparam int ADC_BITS     = 12;
    localparam int SCALE_BITS   = 16;
    localparam int CUR_BITS     = 16;
    localparam int VAL_BITS     = 16;
    localparam int FLUX_BITS    = 14;
    localparam int X_BITS       = 12;
    localparam int DX_BITS      = 10;
    localparam int CAL_SAMPLES  = 100;
    localparam int CNT_BITS     = 7;
    localparam int SUM_BITS     = 19;
    localparam int TABLE_POINTS = 5;
    localparam int NUM_TABLES   = 5;
    localparam int TBL_BITS     = $clog2(NUM_TABLES);
    localparam int PT_BITS      = $clog2(TABLE_POINTS);
    localparam int SEG_BITS     = $clog2(TABLE_POINTS - 1);
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_BITS     = 16;
    localparam int IN_DATA_BITS = 16;
    localparam int IN_USER_BITS = 2;
    localparam int OUT_USER_BITS = 2;
    localparam int OUT_FIELD_BITS = CUR_BITS + 4 * VAL_BITS + FLUX_BITS + ADC_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    localparam logic [ADC_BITS-1:0]   THR_RESET   = ADC_BITS'(124);
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(3345);
    localparam logic [ADC_BITS-1:0]   ZERO_RESET  = ADC_BITS'(2069);

    localparam logic [1:0] REQ_MEAS = 2'd0;
    localparam logic [1:0] REQ_CAL  = 2'd1;
    localparam logic [1:0] REQ_CLR  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THR   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE = CFG_IDX_BITS'(1);

    localparam logic [TBL_BITS-1:0] TBL_LAST = TBL_BITS'(NUM_TABLES - 1);

    localparam logic [X_BITS-1:0] BRK_MA [TABLE_POINTS] = '{
        X_BITS'(0), X_BITS'(500), X_BITS'(1000), X_BITS'(2000), X_BITS'(2920)
    };

    localparam logic [VAL_BITS-1:0] LUT [NUM_TABLES][TABLE_POINTS] = '{
        '{16'd38100, 16'd37990, 16'd35250, 16'd22120, 16'd19220},
        '{16'd30130, 16'd29860, 16'd27340, 16'd16090, 16'd14090},
        '{16'd46070, 16'd46130, 16'd43160, 16'd28150, 16'd24350},
        '{16'd15940, 16'd16270, 16'd15820, 16'd12060, 16'd10260},
        '{16'd3080,  16'd6800,  16'd10080, 16'd12410, 16'd13200}
    };

    localparam int SPAN0 = 500;
    localparam int SPAN1 = 500;
    localparam int SPAN2 = 1000;
    localparam int SPAN3 = 920;

    localparam logic [DX_BITS-1:0] SPAN [TABLE_POINTS-1] = '{
        DX_BITS'(SPAN0), DX_BITS'(SPAN1), DX_BITS'(SPAN2), DX_BITS'(SPAN3)
    };

    // The rounded quotient is taken exactly as floor(n * m / 2^(N+L)) with
    // m = ceil(2^(N+L) / span), n below 2^N and span no larger than 2^L.
    localparam int NUM_BITS    = VAL_BITS + DX_BITS;
    localparam int RECIP_SHIFT = NUM_BITS + DX_BITS;
    localparam int RECIP_BITS  = 28;
    localparam int RPROD_BITS  = NUM_BITS + RECIP_BITS;

    localparam logic [RECIP_BITS-1:0] RECIP [TABLE_POINTS-1] = '{
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(SPAN0) - 64'd1) / 64'(SPAN0)),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(SPAN1) - 64'd1) / 64'(SPAN1)),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(SPAN2) - 64'd1) / 64'(SPAN2)),
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(SPAN3) - 64'd1) / 64'(SPAN3))
    };

    localparam int CAL_NUM_BITS   = SUM_BITS + 1;
    localparam int CAL_SHIFT      = CAL_NUM_BITS + $clog2(CAL_SAMPLES);
    localparam int CAL_RECIP_BITS = CAL_SHIFT - $clog2(CAL_SAMPLES) + 2;
    localparam int CAL_PROD_BITS  = CAL_NUM_BITS + CAL_RECIP_BITS;
    localparam logic [CAL_RECIP_BITS-1:0] CAL_RECIP =
        CAL_RECIP_BITS'(((64'd1 << CAL_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_TPROD,
        ST_TRECIP,
        ST_TSTORE,
        ST_CAL_ACC,
        ST_CAL_DIV,
        ST_CAL_SET,
        ST_DONE
    } fcspl_state_t;

    typedef struct packed {
        logic                capture;
        logic                clr_fault;
        logic                meas;
        logic                sat;
        logic                tprod;
        logic                trecip;
        logic                tstore;
        logic                cal_acc;
        logic                cal_div;
        logic                cal_set;
        logic                out_load;
        logic [TBL_BITS-1:0] tbl;
    } fcspl_cmd_t;

    typedef struct packed {
        logic cal_fill;
    } fcspl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fcspl_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fcspl_dp (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire fcspl_pkg::fcspl_cmd_t                cmd,
    output fcspl_pkg::fcspl_stat_t                    stat,
    input  wire logic [1:0]                           in_req,
    input  wire logic [fcspl_pkg::ADC_BITS-1:0]       in_code,
    input  wire logic                                 cfg_we,
    input  wire logic [fcspl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [fcspl_pkg::CFG_BITS-1:0]       cfg_data,
    output logic [fcspl_pkg::OUT_DATA_BITS-1:0]       out_data,
    output logic [fcspl_pkg::OUT_USER_BITS-1:0]       out_user
);
    import fcspl_pkg::*;

    logic [ADC_BITS-1:0]          thr_reg;
    logic [SCALE_BITS-1:0]        scale_reg;
    logic                         fault_reg, fault_next;
    logic [ADC_BITS-1:0]          zero_reg;
    logic [SUM_BITS-1:0]          cal_sum_reg;
    logic [CNT_BITS-1:0]          cal_cnt_reg;
    logic                         done_reg;
    logic [1:0]                   req_reg;
    logic [ADC_BITS-1:0]          code_reg;
    logic [ADC_BITS+SCALE_BITS-1:0] prod_reg;
    logic                         zcur_reg;
    logic [CUR_BITS-1:0]          cur_reg, cur_next;
    logic [SEG_BITS-1:0]          seg_reg, seg_next;
    logic [DX_BITS-1:0]           dx_reg, dx_next;
    logic [NUM_BITS-1:0]          num_reg;
    logic [VAL_BITS-1:0]          y0_reg;
    logic                         down_reg;
    logic [RPROD_BITS-1:0]        rp_reg;
    logic [VAL_BITS-1:0]          vals_reg [NUM_TABLES];
    logic [CAL_PROD_BITS-1:0]     cal_prod_reg;
    logic [OUT_DATA_BITS-1:0]     out_data_reg;
    logic [OUT_USER_BITS-1:0]     out_user_reg;

    logic [ADC_BITS-1:0]          diff;
    logic [ADC_BITS+SCALE_BITS-8-1:0] p_shift;
    logic [X_BITS-1:0]            xc;
    logic [PT_BITS-1:0]           seg_lo, seg_hi;
    logic [VAL_BITS-1:0]          y0, y1, dy;
    logic                         down;
    logic [VAL_BITS-1:0]          quot;
    logic [SUM_BITS-1:0]          sum_new;
    logic [CNT_BITS-1:0]          cnt_new;
    logic                         meas_out;
    logic [OUT_FIELD_BITS-1:0]    fields;

    assign diff      = code_reg - zero_reg;
    assign p_shift   = prod_reg[ADC_BITS+SCALE_BITS-1:8];
    assign sum_new   = cal_sum_reg + SUM_BITS'(code_reg);
    assign cnt_new   = cal_cnt_reg + CNT_BITS'(1);
    assign stat.cal_fill = cnt_new >= CNT_BITS'(CAL_SAMPLES);

    always_comb begin
        fault_next = fault_reg;
        if (cmd.meas && (code_reg < thr_reg)) begin
            fault_next = 1'b1;
        end
        if (cmd.clr_fault) begin
            fault_next = 1'b0;
        end
        if (cmd.cal_acc && (cal_cnt_reg == '0)) begin
            fault_next = 1'b0;
        end
    end

    always_comb begin
        if (zcur_reg) begin
            cur_next = '0;
        end else if (|p_shift[ADC_BITS+SCALE_BITS-8-1:CUR_BITS]) begin
            cur_next = '1;
        end else begin
            cur_next = p_shift[CUR_BITS-1:0];
        end
        if (cur_next >= CUR_BITS'(BRK_MA[TABLE_POINTS-1])) begin
            xc = BRK_MA[TABLE_POINTS-1];
        end else begin
            xc = cur_next[X_BITS-1:0];
        end
        seg_next = '0;
        for (int j = 1; j < TABLE_POINTS - 1; j++) begin
            if (xc > BRK_MA[j]) begin
                seg_next = SEG_BITS'(j);
            end
        end
        dx_next = DX_BITS'(xc - BRK_MA[PT_BITS'(seg_next)]);
    end

    assign seg_lo = PT_BITS'(seg_reg);
    assign seg_hi = seg_lo + PT_BITS'(1);
    assign y0     = LUT[cmd.tbl][seg_lo];
    assign y1     = LUT[cmd.tbl][seg_hi];
    assign down   = y1 < y0;
    assign dy     = down ? (y0 - y1) : (y1 - y0);
    assign quot   = rp_reg[RECIP_SHIFT +: VAL_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THR_RESET;
            scale_reg   <= SCALE_RESET;
            fault_reg   <= 1'b0;
            zero_reg    <= ZERO_RESET;
            cal_sum_reg <= '0;
            cal_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_THR:   thr_reg   <= cfg_data[ADC_BITS-1:0];
                    CFG_SCALE: scale_reg <= cfg_data[SCALE_BITS-1:0];
                    default:   thr_reg   <= thr_reg;
                endcase
            end
            fault_reg <= fault_next;
            if (cmd.capture) begin
                done_reg <= 1'b0;
            end
            if (cmd.cal_acc) begin
                cal_sum_reg <= sum_new;
                cal_cnt_reg <= cnt_new;
            end
            if (cmd.cal_set) begin
                zero_reg    <= cal_prod_reg[CAL_SHIFT +: ADC_BITS];
                cal_sum_reg <= '0;
                cal_cnt_reg <= '0;
                done_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg  <= in_req;
            code_reg <= in_code;
        end
        if (cmd.meas) begin
            prod_reg <= (ADC_BITS+SCALE_BITS)'(diff) * (ADC_BITS+SCALE_BITS)'(scale_reg);
            zcur_reg <= fault_reg || (code_reg < thr_reg) || (code_reg <= zero_reg);
        end
        if (cmd.sat) begin
            cur_reg <= cur_next;
            seg_reg <= seg_next;
            dx_reg  <= dx_next;
        end
        if (cmd.tprod) begin
            num_reg  <= NUM_BITS'(dy) * NUM_BITS'(dx_reg)
                        + NUM_BITS'(SPAN[seg_reg] >> 1);
            y0_reg   <= y0;
            down_reg <= down;
        end
        if (cmd.trecip) begin
            rp_reg <= RPROD_BITS'(num_reg) * RPROD_BITS'(RECIP[seg_reg]);
        end
        if (cmd.tstore) begin
            vals_reg[cmd.tbl] <= down_reg ? (y0_reg - quot) : (y0_reg + quot);
        end
        if (cmd.cal_div) begin
            cal_prod_reg <= CAL_PROD_BITS'(CAL_NUM_BITS'(cal_sum_reg)
                            + CAL_NUM_BITS'(CAL_SAMPLES / 2)) * CAL_PROD_BITS'(CAL_RECIP);
        end
        if (cmd.out_load) begin
            out_data_reg <= {{OUT_PAD_BITS{1'b0}}, fields};
            out_user_reg <= {done_reg, fault_reg};
        end
    end

    always_comb begin
        meas_out = req_reg == REQ_MEAS;
        fields   = {zero_reg,
                    meas_out ? vals_reg[4][FLUX_BITS-1:0] : FLUX_BITS'(0),
                    meas_out ? vals_reg[3] : VAL_BITS'(0),
                    meas_out ? vals_reg[2] : VAL_BITS'(0),
                    meas_out ? vals_reg[1] : VAL_BITS'(0),
                    meas_out ? vals_reg[0] : VAL_BITS'(0),
                    meas_out ? cur_reg : CUR_BITS'(0)};
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;

endmodule

`default_nettype wire

// ===== rtl/fcspl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "field_current_sense_and_param_lookup_top_assert.svh"

module fcspl_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output fcspl_pkg::fcspl_cmd_t       cmd,
    input  wire fcspl_pkg::fcspl_stat_t stat
);
    import fcspl_pkg::*;

    fcspl_state_t        state_reg, state_next;
    logic [TBL_BITS-1:0] tbl_reg, tbl_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tbl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tbl_reg     <= tbl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        tbl_next     = tbl_reg;
        m_valid_next = m_valid_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.tbl      = tbl_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (s_tuser)
                        REQ_MEAS: state_next = ST_MUL;
                        REQ_CAL:  state_next = ST_CAL_ACC;
                        REQ_CLR: begin
                            cmd.clr_fault = 1'b1;
                            state_next    = ST_DONE;
                        end
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL: begin
                cmd.meas   = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                tbl_next   = '0;
                state_next = ST_TPROD;
            end
            ST_TPROD: begin
                cmd.tprod  = 1'b1;
                state_next = ST_TRECIP;
            end
            ST_TRECIP: begin
                cmd.trecip = 1'b1;
                state_next = ST_TSTORE;
            end
            ST_TSTORE: begin
                cmd.tstore = 1'b1;
                if (tbl_reg == TBL_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    tbl_next   = tbl_reg + TBL_BITS'(1);
                    state_next = ST_TPROD;
                end
            end
            ST_CAL_ACC: begin
                cmd.cal_acc = 1'b1;
                state_next  = stat.cal_fill ? ST_CAL_DIV : ST_DONE;
            end
            ST_CAL_DIV: begin
                cmd.cal_div = 1'b1;
                state_next  = ST_CAL_SET;
            end
            ST_CAL_SET: begin
                cmd.cal_set = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;

    `FCSPL_ASSERT_IMPL(a_load_slot, cmd.out_load, !m_valid_reg || m_tready)
    `FCSPL_ASSERT_NEXT(a_meas_start, s_tvalid && s_tready && s_tuser == REQ_MEAS, state_reg == ST_MUL)
    `FCSPL_ASSERT_NEXT(a_tbl_exit, state_reg == ST_TSTORE && tbl_reg == TBL_LAST, state_reg == ST_DONE)
    `FCSPL_ASSERT_IMPL(a_tbl_range, state_reg == ST_TPROD, tbl_reg <= TBL_LAST)

endmodule

`default_nettype wire

// ===== rtl/field_current_sense_and_param_lookup_top.sv =====
// A measure request does the scale multiply and saturation, then runs the five table
// interpolations one after another through one shared divide unit (product, reciprocal, store).
// A calibration sample is accumulated, then divided and set when the run is full; a clear or
// unused request goes straight to the output. No new request is taken until the result is loaded.
// Reset (aresetn low at a clock edge) restores the config registers, fault, offset and calibration.
`timescale 1ns / 1ps
`default_nettype none

module field_current_sense_and_param_lookup_top (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // adc_code, then zero padding.
    input  wire logic [fcspl_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // req_type.
    input  wire logic [fcspl_pkg::IN_USER_BITS-1:0]     s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // current_ma, ls_nh, ld_nh, lq_nh, ld_lq_gap_nh, flux_uwb, zero_offset_code, zero padding.
    output logic [fcspl_pkg::OUT_DATA_BITS-1:0]         m_tdata,
    // sensor_fault, calibration_done.
    output logic [fcspl_pkg::OUT_USER_BITS-1:0]         m_tuser,
    input  wire logic                                   cfg_we,
    input  wire logic [fcspl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [fcspl_pkg::CFG_BITS-1:0]         cfg_data
);
    import fcspl_pkg::*;

    fcspl_cmd_t  cmd;
    fcspl_stat_t stat;

    fcspl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    fcspl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_req    (s_tuser),
        .in_code   (s_tdata[ADC_BITS-1:0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/field_current_sense_and_param_lookup_top_tb.sv =====
`timescale 1ns / 1ps

module field_current_sense_and_param_lookup_top_tb;

    import fcspl_pkg::*;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int unsigned CAL_RUN = 100;

    localparam int unsigned BRK [5] = '{0, 500, 1000, 2000, 2920};
    localparam int unsigned CURVE [5][5] = '{
        '{38100, 37990, 35250, 22120, 19220},
        '{30130, 29860, 27340, 16090, 14090},
        '{46070, 46130, 43160, 28150, 24350},
        '{15940, 16270, 15820, 12060, 10260},
        '{3080,  6800,  10080, 12410, 13200}
    };

    typedef struct packed {
        logic [CUR_BITS-1:0]  cur;
        logic                 fault;
        logic [VAL_BITS-1:0]  ls;
        logic [VAL_BITS-1:0]  ld;
        logic [VAL_BITS-1:0]  lq;
        logic [VAL_BITS-1:0]  gap;
        logic [FLUX_BITS-1:0] flux;
        logic                 done;
        logic [ADC_BITS-1:0]  zoff;
    } lookup_t;

    typedef struct {
        logic [1:0]          req;
        logic [ADC_BITS-1:0] code;
        bit                  typed;
        lookup_t             res;
    } row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata;
    logic [IN_USER_BITS-1:0]   s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic [OUT_USER_BITS-1:0]  m_tuser;
    logic                      cfg_we;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;

    logic [ADC_BITS-1:0]   thr_q;
    logic [SCALE_BITS-1:0] scale_q;
    logic                  fault_q;
    logic [ADC_BITS-1:0]   offset_q;
    int unsigned           cal_acc;
    int unsigned           cal_cnt;

    lookup_t pending_q [$];
    int      mismatches;
    int      idle_pct;
    int      rdy_hold;
    int      cal_left;
    int      cal_mode;

    row_t                  plan [20];
    logic [ADC_BITS-1:0]   phase_thr [6];
    logic [SCALE_BITS-1:0] phase_scale [6];
    int                    phase_items [6] = '{230, 230, 120, 240, 240, 240};
    int                    phase_idle [6] = '{25, 10, 0, 30, 15, 0};

    field_current_sense_and_param_lookup_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("field_current_sense_and_param_lookup_top_tb: errors");
        $finish;
    end

    function automatic int unsigned interp(input int unsigned x, input int t);
        int unsigned y0;
        int unsigned y1;
        int unsigned dy;
        int unsigned span;
        int unsigned stp;
        if (x <= BRK[0]) return CURVE[t][0];
        if (x >= BRK[4]) return CURVE[t][4];
        for (int k = 0; k < 4; k++) begin
            if (x >= BRK[k] && x <= BRK[k+1]) begin
                y0 = CURVE[t][k];
                y1 = CURVE[t][k+1];
                dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
                span = BRK[k+1] - BRK[k];
                stp = (dy * (x - BRK[k]) + span / 2) / span;
                return (y1 >= y0) ? y0 + stp : y0 - stp;
            end
        end
        return CURVE[t][0];
    endfunction

    function automatic lookup_t predict_lookup(input logic [1:0] req,
                                               input logic [ADC_BITS-1:0] code);
        lookup_t r;
        longint unsigned prod;
        int unsigned cur;
        r = '0;
        cur = 0;
        case (req)
            REQ_MEAS: begin
                if (code < thr_q) fault_q = 1'b1;
                if (!fault_q && code > offset_q) begin
                    prod = ((64'(code) - 64'(offset_q)) * 64'(scale_q)) >> 8;
                    cur = (prod > 65535) ? 65535 : int'(prod);
                end
                r.cur  = CUR_BITS'(cur);
                r.ls   = VAL_BITS'(interp(cur, 0));
                r.ld   = VAL_BITS'(interp(cur, 1));
                r.lq   = VAL_BITS'(interp(cur, 2));
                r.gap  = VAL_BITS'(interp(cur, 3));
                r.flux = FLUX_BITS'(interp(cur, 4));
            end
            REQ_CAL: begin
                if (cal_cnt == 0) fault_q = 1'b0;
                cal_acc = (cal_acc + code) & 32'h7FFFF;
                cal_cnt = (cal_cnt + 1) & 32'h7F;
                if (cal_cnt >= CAL_RUN) begin
                    offset_q = ADC_BITS'((cal_acc + CAL_RUN / 2) / CAL_RUN);
                    r.done = 1'b1;
                    cal_acc = 0;
                    cal_cnt = 0;
                end
            end
            REQ_CLR: begin
                fault_q = 1'b0;
            end
            default: begin
            end
        endcase
        r.fault = fault_q;
        r.zoff  = offset_q;
        return r;
    endfunction

    task automatic run_item(input logic [1:0] req, input logic [ADC_BITS-1:0] code,
                            input bit typed, input lookup_t res, input bit drain);
        lookup_t want;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_BITS'(code);
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_lookup(req, code);
        if (typed) want = res;
        pending_q.push_back(want);
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0 || drain) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            if (drain) begin
                while (pending_q.size() != 0) @(posedge aclk);
            end
        end
    endtask

    task automatic set_config(input logic [ADC_BITS-1:0] thr, input logic [SCALE_BITS-1:0] scale);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_THR;
        cfg_data  <= {4'($urandom_range(0, 15)), thr};
        @(posedge aclk);
        thr_q = thr;
        cfg_index <= CFG_SCALE;
        cfg_data  <= scale;
        @(posedge aclk);
        scale_q = scale;
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        logic [1:0] req;
        logic [ADC_BITS-1:0] code;
        int pick;
        int dmax;
        int c;
        for (int n = 0; n < count; n++) begin
            if (cal_left == 0 && $urandom_range(0, 79) == 0) begin
                cal_left = CAL_RUN;
                cal_mode = $urandom_range(0, 7);
            end
            pick = $urandom_range(0, 99);
            code = ADC_BITS'($urandom_range(0, 4095));
            if (cal_left > 0 && pick < 75) begin
                req = REQ_CAL;
                cal_left--;
                case (cal_mode)
                    0: code = ADC_BITS'($urandom_range(0, 4095));
                    1: code = '0;
                    2: code = '1;
                    default: code = ADC_BITS'($urandom_range(1900, 2250));
                endcase
            end else if (pick < 88) begin
                req = REQ_MEAS;
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    code = ADC_BITS'($urandom_range(0, 200));
                end else if (pick > 2) begin
                    dmax = (scale_q == 0) ? 4095 : 3300 * 256 / int'(scale_q) + 2;
                    c = int'(offset_q) + int'($urandom_range(0, dmax));
                    code = (c > 4095) ? '1 : ADC_BITS'(c);
                end
            end else if (pick < 94) begin
                req = REQ_CLR;
            end else if (pick < 97) begin
                req = REQ_SPARE;
            end else begin
                req = REQ_CAL;
            end
            run_item(req, code, 1'b0, '0, n == count - 1 || $urandom_range(0, 149) == 0);
        end
    endtask

    initial begin
        m_tready <= 1'b0;
        rdy_hold = 0;
        forever begin
            @(posedge aclk);
            if (rdy_hold > 0) begin
                rdy_hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                rdy_hold = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        lookup_t got;
        lookup_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.cur   = m_tdata[15:0];
            got.ls    = m_tdata[31:16];
            got.ld    = m_tdata[47:32];
            got.lq    = m_tdata[63:48];
            got.gap   = m_tdata[79:64];
            got.flux  = m_tdata[93:80];
            got.zoff  = m_tdata[105:94];
            got.fault = m_tuser[0];
            got.done  = m_tuser[1];
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no request outstanding: %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp cur=%0d flt=%0b ls=%0d ld=%0d lq=%0d gap=%0d flux=%0d done=%0b off=%0d",
                                 want.cur, want.fault, want.ls, want.ld, want.lq, want.gap,
                                 want.flux, want.done, want.zoff);
                        $display("         got cur=%0d flt=%0b ls=%0d ld=%0d lq=%0d gap=%0d flux=%0d done=%0b off=%0d",
                                 got.cur, got.fault, got.ls, got.ld, got.lq, got.gap,
                                 got.flux, got.done, got.zoff);
                    end
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_MEAS;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_THR;
        cfg_data  <= '0;
        thr_q      = 12'd124;
        scale_q    = 16'd3345;
        fault_q    = 1'b0;
        offset_q   = 12'd2069;
        cal_acc    = 0;
        cal_cnt    = 0;
        mismatches = 0;
        idle_pct   = 20;
        cal_left   = 0;
        cal_mode   = 0;

        // The calibration run opened here is only finished by the random part.
        plan = '{
            '{REQ_MEAS, 12'd0, 1'b1,
              '{16'd0, 1'b1, 16'd38100, 16'd30130, 16'd46070, 16'd15940, 14'd3080, 1'b0, 12'd2069}},
            '{REQ_MEAS, 12'd4095, 1'b1,
              '{16'd0, 1'b1, 16'd38100, 16'd30130, 16'd46070, 16'd15940, 14'd3080, 1'b0, 12'd2069}},
            '{REQ_CLR, 12'd4095, 1'b1,
              '{16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0, 1'b0, 12'd2069}},
            '{REQ_MEAS, 12'd4095, 1'b1,
              '{16'd26472, 1'b0, 16'd19220, 16'd14090, 16'd24350, 16'd10260, 14'd13200,
                1'b0, 12'd2069}},
            '{REQ_MEAS, 12'd2069, 1'b1,
              '{16'd0, 1'b0, 16'd38100, 16'd30130, 16'd46070, 16'd15940, 14'd3080, 1'b0, 12'd2069}},
            '{REQ_MEAS, 12'd124, 1'b1,
              '{16'd0, 1'b0, 16'd38100, 16'd30130, 16'd46070, 16'd15940, 14'd3080, 1'b0, 12'd2069}},
            '{REQ_MEAS, 12'd123, 1'b1,
              '{16'd0, 1'b1, 16'd38100, 16'd30130, 16'd46070, 16'd15940, 14'd3080, 1'b0, 12'd2069}},
            '{REQ_SPARE, 12'd4095, 1'b1,
              '{16'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0, 1'b0, 12'd2069}},
            '{REQ_CAL, 12'd2000, 1'b1,
              '{16'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0, 1'b0, 12'd2069}},
            '{REQ_MEAS, 12'd100, 1'b0, '0},
            '{REQ_CAL, 12'd2000, 1'b0, '0},
            '{REQ_CLR, 12'd0, 1'b0, '0},
            '{REQ_MEAS, 12'd2070, 1'b0, '0},
            '{REQ_MEAS, 12'd2107, 1'b0, '0},
            '{REQ_MEAS, 12'd2108, 1'b0, '0},
            '{REQ_MEAS, 12'd2146, 1'b0, '0},
            '{REQ_MEAS, 12'd2222, 1'b0, '0},
            '{REQ_MEAS, 12'd2292, 1'b0, '0},
            '{REQ_MEAS, 12'd2293, 1'b0, '0},
            '{REQ_MEAS, 12'd3000, 1'b0, '0}
        };

        phase_thr   = '{12'd124, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd124};
        phase_scale = '{16'd3345, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0};
        phase_thr[3]   = ADC_BITS'($urandom_range(0, 400));
        phase_scale[3] = SCALE_BITS'($urandom_range(0, 65535));
        phase_thr[4]   = ADC_BITS'($urandom_range(0, 4095));
        phase_scale[4] = SCALE_BITS'($urandom_range(1, 8000));
        phase_scale[5] = SCALE_BITS'($urandom_range(0, 65535));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            run_item(plan[i].req, plan[i].code, plan[i].typed, plan[i].res, i == 19);
        end

        for (int p = 0; p < 6; p++) begin
            repeat (20) @(posedge aclk);
            set_config(phase_thr[p], phase_scale[p]);
            idle_pct = phase_idle[p];
            run_phase(phase_items[p]);
        end

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("field_current_sense_and_param_lookup_top_tb: clean");
        end else begin
            $display("field_current_sense_and_param_lookup_top_tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fcspl_pkg.sv
rtl/fcspl_dp.sv
rtl/fcspl_ctrl.sv
rtl/field_current_sense_and_param_lookup_top.sv
tb/field_current_sense_and_param_lookup_top_tb.sv
